@@ hdl/gscw_pkg.sv @@
package gscw_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 2'd2;

  localparam int DIM_CFG_W = 4;
  localparam int LIMIT_W = 10;
  localparam int TURN_W = 3;
  localparam int ORDER_W = 7;
  localparam int COORD_W = 3;

  localparam logic [DIM_CFG_W-1:0] ROWS_RESET = 4'd6;
  localparam logic [DIM_CFG_W-1:0] COLS_RESET = 4'd6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;
  localparam logic [TURN_W-1:0] TURNS_FULL = 3'd4;

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  typedef enum logic {
    END_DEADLOCK = 1'b0,
    END_LIMIT    = 1'b1
  } end_reason_t;

  typedef enum logic [4:0] {
    S_LOAD    = 5'b00001,
    S_CLEAR   = 5'b00010,
    S_ATTEMPT = 5'b00100,
    S_CHECK   = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

endpackage

@@ hdl/gscw_ifs.sv @@
interface gscw_cell_if;
  logic valid;
  logic ready;
  logic cell_blocked;
  logic last_cell;
  modport source (output valid, output cell_blocked, output last_cell, input ready);
  modport sink (input valid, input cell_blocked, input last_cell, output ready);
endinterface

interface gscw_visit_if;
  logic valid;
  logic ready;
  logic [gscw_pkg::COORD_W-1:0] visit_row;
  logic [gscw_pkg::COORD_W-1:0] visit_col;
  logic [gscw_pkg::ORDER_W-1:0] visit_order;
  logic last_visit;
  logic end_reason;
  modport source (output valid, output visit_row, output visit_col, output visit_order,
                  output last_visit, output end_reason, input ready);
  modport sink (input valid, input visit_row, input visit_col, input visit_order,
                input last_visit, input end_reason, output ready);
endinterface

interface gscw_cfg_if;
  logic valid;
  logic ready;
  logic [gscw_pkg::CFG_IDX_W-1:0] index;
  logic [gscw_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/gscw_ram.sv @@
module gscw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/grid_spiral_coverage_walker_core.sv @@
// Grid spiral coverage walker. Load one grid cell per item in raster order (grid_cols cells
// per row), one cell per cycle. The item with last_cell set starts a walk from the top-left
// cell heading right: first a clearing pass over all MAX_DIM*MAX_DIM cells of the visited
// memory, then each attempt reads the blocked and visited memories, then checks and writes
// back, or turns without a read when the next cell lies outside the grid, and then the
// final result is sent. One result leaves per visited cell;
// the last one carries last_visit and the end reason. A stalled output pauses the walk.
// Cell items are taken again as soon as the walk has ended.
module grid_spiral_coverage_walker_core #(
  parameter int MAX_DIM = 8
) (
  input  logic         clk,
  input  logic         rst,
  gscw_cell_if.sink    cell_in,
  gscw_visit_if.source visit_out,
  gscw_cfg_if.sink     cfg
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int NXT_W = POS_W + 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  logic [gscw_pkg::DIM_CFG_W-1:0] grid_rows;
  logic [gscw_pkg::DIM_CFG_W-1:0] grid_cols;
  logic [gscw_pkg::LIMIT_W-1:0] step_limit;

  gscw_pkg::state_t state, state_next;
  logic [ADDR_W-1:0] load_index, load_index_next;
  logic [ADDR_W-1:0] clr_idx, clr_idx_next;
  logic [POS_W-1:0] pos_row, pos_row_next;
  logic [POS_W-1:0] pos_col, pos_col_next;
  gscw_pkg::heading_t heading, heading_next;
  logic [gscw_pkg::LIMIT_W-1:0] attempt_count, attempt_count_next;
  logic [gscw_pkg::TURN_W-1:0] turns_left, turns_left_next;
  logic [POS_W-1:0] cand_row, cand_row_next;
  logic [POS_W-1:0] cand_col, cand_col_next;
  logic [ADDR_W-1:0] cand_addr, cand_addr_next;
  logic [POS_W-1:0] pend_row, pend_row_next;
  logic [POS_W-1:0] pend_col, pend_col_next;
  logic [gscw_pkg::ORDER_W-1:0] pend_order, pend_order_next;
  gscw_pkg::end_reason_t reason, reason_next;

  logic out_valid;
  logic [gscw_pkg::COORD_W-1:0] out_row;
  logic [gscw_pkg::COORD_W-1:0] out_col;
  logic [gscw_pkg::ORDER_W-1:0] out_order;
  logic out_last;
  logic out_reason;
  logic out_push;
  logic push_last;
  logic out_free;

  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic [NXT_W-1:0] nr;
  logic [NXT_W-1:0] nc;
  logic under;
  logic in_range;
  logic [ADDR_W+1:0] addr_full;
  logic [gscw_pkg::LIMIT_W-1:0] attempt_inc;

  logic blk_we;
  logic blk_re;
  logic blk_rdata;
  logic vis_we;
  logic [ADDR_W-1:0] vis_waddr;
  logic vis_wdata;
  logic vis_rdata;
  logic cell_acc;
  logic cell_free;

  assign cfg.ready = 1'b1;
  assign cell_in.ready = (state == gscw_pkg::S_LOAD);
  assign cell_acc = cell_in.valid && cell_in.ready;
  assign out_free = !out_valid || visit_out.ready;
  assign cell_free = !blk_rdata && !vis_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= gscw_pkg::ROWS_RESET;
      grid_cols <= gscw_pkg::COLS_RESET;
      step_limit <= gscw_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        gscw_pkg::REG_GRID_ROWS: grid_rows <= cfg.data[gscw_pkg::DIM_CFG_W-1:0];
        gscw_pkg::REG_GRID_COLS: grid_cols <= cfg.data[gscw_pkg::DIM_CFG_W-1:0];
        gscw_pkg::REG_STEP_LIMIT: step_limit <= cfg.data[gscw_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] eff_dim(input logic [gscw_pkg::DIM_CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign rows_eff = eff_dim(grid_rows);
  assign cols_eff = eff_dim(grid_cols);

  always_comb begin
    nr = NXT_W'(pos_row);
    nc = NXT_W'(pos_col);
    under = 1'b0;
    case (heading)
      gscw_pkg::HEAD_RIGHT: nc = NXT_W'(pos_col) + NXT_W'(1);
      gscw_pkg::HEAD_DOWN: nr = NXT_W'(pos_row) + NXT_W'(1);
      gscw_pkg::HEAD_LEFT: begin
        under = (pos_col == '0);
        nc = NXT_W'(pos_col) - NXT_W'(1);
      end
      default: begin
        under = (pos_row == '0);
        nr = NXT_W'(pos_row) - NXT_W'(1);
      end
    endcase
  end

  assign in_range = !under && (nr < NXT_W'(rows_eff)) && (nc < NXT_W'(cols_eff));
  assign addr_full = (ADDR_W + 2)'(nr) * (ADDR_W + 2)'(cols_eff) + (ADDR_W + 2)'(nc);
  assign attempt_inc = attempt_count + gscw_pkg::LIMIT_W'(1);
  assign blk_we = cell_acc;
  assign blk_re = (state == gscw_pkg::S_ATTEMPT) && in_range;

  always_comb begin
    state_next = state;
    load_index_next = load_index;
    clr_idx_next = clr_idx;
    pos_row_next = pos_row;
    pos_col_next = pos_col;
    heading_next = heading;
    attempt_count_next = attempt_count;
    turns_left_next = turns_left;
    cand_row_next = cand_row;
    cand_col_next = cand_col;
    cand_addr_next = cand_addr;
    pend_row_next = pend_row;
    pend_col_next = pend_col;
    pend_order_next = pend_order;
    reason_next = reason;
    out_push = 1'b0;
    push_last = 1'b0;
    vis_we = 1'b0;
    vis_waddr = clr_idx;
    vis_wdata = 1'b0;
    case (state)
      gscw_pkg::S_LOAD: begin
        if (cell_acc) begin
          load_index_next = (load_index == LAST_ADDR) ? '0 : load_index + ADDR_W'(1);
          if (cell_in.last_cell) begin
            load_index_next = '0;
            clr_idx_next = '0;
            pos_row_next = '0;
            pos_col_next = '0;
            heading_next = gscw_pkg::HEAD_RIGHT;
            attempt_count_next = '0;
            turns_left_next = gscw_pkg::TURNS_FULL;
            pend_row_next = '0;
            pend_col_next = '0;
            pend_order_next = gscw_pkg::ORDER_W'(1);
            state_next = gscw_pkg::S_CLEAR;
          end
        end
      end
      gscw_pkg::S_CLEAR: begin
        vis_we = 1'b1;
        vis_waddr = clr_idx;
        vis_wdata = (clr_idx == '0);
        clr_idx_next = clr_idx + ADDR_W'(1);
        if (clr_idx == LAST_ADDR) begin
          if (step_limit == '0) begin
            reason_next = gscw_pkg::END_LIMIT;
            state_next = gscw_pkg::S_FINISH;
          end else begin
            state_next = gscw_pkg::S_ATTEMPT;
          end
        end
      end
      gscw_pkg::S_ATTEMPT: begin
        cand_row_next = nr[POS_W-1:0];
        cand_col_next = nc[POS_W-1:0];
        cand_addr_next = addr_full[ADDR_W-1:0];
        if (in_range) begin
          state_next = gscw_pkg::S_CHECK;
        end else begin
          heading_next = gscw_pkg::heading_t'(heading + 2'd1);
          turns_left_next = turns_left - gscw_pkg::TURN_W'(1);
          if (turns_left == gscw_pkg::TURN_W'(1)) begin
            reason_next = gscw_pkg::END_DEADLOCK;
            state_next = gscw_pkg::S_FINISH;
          end else begin
            attempt_count_next = attempt_inc;
            if (attempt_inc >= step_limit) begin
              reason_next = gscw_pkg::END_LIMIT;
              state_next = gscw_pkg::S_FINISH;
            end
          end
        end
      end
      gscw_pkg::S_CHECK: begin
        if (cell_free) begin
          if (out_free) begin
            out_push = 1'b1;
            vis_we = 1'b1;
            vis_waddr = cand_addr;
            vis_wdata = 1'b1;
            pos_row_next = cand_row;
            pos_col_next = cand_col;
            pend_row_next = cand_row;
            pend_col_next = cand_col;
            pend_order_next = pend_order + gscw_pkg::ORDER_W'(1);
            turns_left_next = gscw_pkg::TURNS_FULL;
            attempt_count_next = attempt_inc;
            if (attempt_inc >= step_limit) begin
              reason_next = gscw_pkg::END_LIMIT;
              state_next = gscw_pkg::S_FINISH;
            end else begin
              state_next = gscw_pkg::S_ATTEMPT;
            end
          end
        end else begin
          heading_next = gscw_pkg::heading_t'(heading + 2'd1);
          turns_left_next = turns_left - gscw_pkg::TURN_W'(1);
          if (turns_left == gscw_pkg::TURN_W'(1)) begin
            reason_next = gscw_pkg::END_DEADLOCK;
            state_next = gscw_pkg::S_FINISH;
          end else begin
            attempt_count_next = attempt_inc;
            if (attempt_inc >= step_limit) begin
              reason_next = gscw_pkg::END_LIMIT;
              state_next = gscw_pkg::S_FINISH;
            end else begin
              state_next = gscw_pkg::S_ATTEMPT;
            end
          end
        end
      end
      gscw_pkg::S_FINISH: begin
        if (out_free) begin
          out_push = 1'b1;
          push_last = 1'b1;
          state_next = gscw_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = gscw_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gscw_pkg::S_LOAD;
      load_index <= '0;
      clr_idx <= '0;
      pos_row <= '0;
      pos_col <= '0;
      heading <= gscw_pkg::HEAD_RIGHT;
      attempt_count <= '0;
      turns_left <= gscw_pkg::TURNS_FULL;
      pend_order <= gscw_pkg::ORDER_W'(1);
      reason <= gscw_pkg::END_LIMIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      load_index <= load_index_next;
      clr_idx <= clr_idx_next;
      pos_row <= pos_row_next;
      pos_col <= pos_col_next;
      heading <= heading_next;
      attempt_count <= attempt_count_next;
      turns_left <= turns_left_next;
      pend_order <= pend_order_next;
      reason <= reason_next;
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (visit_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_row <= cand_row_next;
    cand_col <= cand_col_next;
    cand_addr <= cand_addr_next;
    pend_row <= pend_row_next;
    pend_col <= pend_col_next;
    if (out_push) begin
      out_row <= gscw_pkg::COORD_W'(pend_row);
      out_col <= gscw_pkg::COORD_W'(pend_col);
      out_order <= pend_order;
      out_last <= push_last;
      out_reason <= push_last ? reason : 1'b0;
    end
  end

  assign visit_out.valid = out_valid;
  assign visit_out.visit_row = out_row;
  assign visit_out.visit_col = out_col;
  assign visit_out.visit_order = out_order;
  assign visit_out.last_visit = out_last;
  assign visit_out.end_reason = out_reason;

  gscw_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_blocked_ram (
    .clk  (clk),
    .we   (blk_we),
    .waddr(load_index),
    .wdata(cell_in.cell_blocked),
    .re   (blk_re),
    .raddr(addr_full[ADDR_W-1:0]),
    .rdata(blk_rdata)
  );

  gscw_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_visited_ram (
    .clk  (clk),
    .we   (vis_we),
    .waddr(vis_waddr),
    .wdata(vis_wdata),
    .re   (blk_re),
    .raddr(addr_full[ADDR_W-1:0]),
    .rdata(vis_rdata)
  );

`ifndef SYNTH
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(vis_we && blk_re))
    else $error("visited memory read and write in the same cycle");

  a_last_starts_clear: assert property (@(posedge clk) disable iff (rst)
    (cell_acc && cell_in.last_cell) |=> (state == gscw_pkg::S_CLEAR))
    else $error("last cell did not start the clearing pass");

  a_turns_live: assert property (@(posedge clk) disable iff (rst)
    ((state == gscw_pkg::S_ATTEMPT) || (state == gscw_pkg::S_CHECK)) |->
      (turns_left != '0 && turns_left <= gscw_pkg::TURNS_FULL))
    else $error("turn count out of range during walk");

  a_under_limit: assert property (@(posedge clk) disable iff (rst)
    (state == gscw_pkg::S_ATTEMPT) |-> (attempt_count < step_limit))
    else $error("attempt taken beyond step limit");

  a_check_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == gscw_pkg::S_CHECK) |->
      (DIM_W'(cand_row) < rows_eff && DIM_W'(cand_col) < cols_eff))
    else $error("checked cell lies outside the grid");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import gscw_pkg::*;

  localparam int GRID_DIM = 8;
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
  localparam int RANDOM_ITEMS = 330;
  localparam int IDLE_GAP = 16;
  localparam int TAIL_CYCLES = 200;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [ORDER_W-1:0] order;
    logic               last;
    end_reason_t        why;
  } visit_t;

  class walk_checker;
    logic [DIM_CFG_W-1:0] rows_cfg;
    logic [DIM_CFG_W-1:0] cols_cfg;
    logic [LIMIT_W-1:0]   limit_cfg;
    bit                   cell_map [GRID_CELLS];
    int unsigned          load_idx;
    visit_t               planned_visits [$];
    int                   errors;

    function new();
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      limit_cfg = LIMIT_RESET;
      foreach (cell_map[i]) cell_map[i] = 1'b0;
      load_idx = 0;
      errors = 0;
    endfunction

    function int eff_dim(logic [DIM_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > GRID_DIM) return GRID_DIM;
      return v;
    endfunction

    function int grid_cells();
      return eff_dim(rows_cfg) * eff_dim(cols_cfg);
    endfunction

    function int pending();
      return planned_visits.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_GRID_ROWS: rows_cfg = value[DIM_CFG_W-1:0];
        REG_GRID_COLS: cols_cfg = value[DIM_CFG_W-1:0];
        REG_STEP_LIMIT: limit_cfg = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function visit_t make_visit(int r, int c, int order);
      visit_t v;
      v.row = r[COORD_W-1:0];
      v.col = c[COORD_W-1:0];
      v.order = order[ORDER_W-1:0];
      v.last = 1'b0;
      v.why = END_DEADLOCK;
      return v;
    endfunction

    function void plan_walk();
      int rows;
      int cols;
      int r;
      int c;
      int nr;
      int nc;
      int tries;
      int turns;
      int order;
      bit moved;
      bit seen [GRID_CELLS];
      logic [1:0] hd;
      end_reason_t why;
      visit_t walk [$];
      rows = eff_dim(rows_cfg);
      cols = eff_dim(cols_cfg);
      foreach (seen[i]) seen[i] = 1'b0;
      r = 0;
      c = 0;
      hd = HEAD_RIGHT;
      tries = 0;
      turns = TURNS_FULL;
      order = 1;
      why = END_LIMIT;
      seen[0] = 1'b1;
      walk = {walk, make_visit(0, 0, order)};
      while (tries < limit_cfg) begin
        nr = r;
        nc = c;
        case (hd)
          HEAD_RIGHT: nc = nc + 1;
          HEAD_DOWN: nr = nr + 1;
          HEAD_LEFT: nc = nc - 1;
          default: nr = nr - 1;
        endcase
        moved = 1'b0;
        if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
          if (!cell_map[nr * cols + nc] && !seen[nr * cols + nc]) begin
            moved = 1'b1;
            r = nr;
            c = nc;
            order = order + 1;
            seen[nr * cols + nc] = 1'b1;
            walk = {walk, make_visit(r, c, order)};
            turns = TURNS_FULL;
          end
        end
        if (!moved) begin
          hd = hd + 2'd1;
          turns = turns - 1;
          if (turns == 0) begin
            why = END_DEADLOCK;
            break;
          end
        end
        tries = tries + 1;
      end
      walk[walk.size() - 1].last = 1'b1;
      walk[walk.size() - 1].why = why;
      planned_visits = {planned_visits, walk};
    endfunction

    function void store_cell(bit blk, bit lst);
      cell_map[load_idx] = blk;
      load_idx = (load_idx + 1) % GRID_CELLS;
      if (lst) begin
        load_idx = 0;
        plan_walk();
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_visit(visit_t got);
      visit_t want;
      if (planned_visits.size() == 0) begin
        report($sformatf("visit (%0d,%0d) #%0d with nothing expected",
                         got.row, got.col, got.order));
        return;
      end
      want = planned_visits.pop_front();
      if (got.row !== want.row)
        report($sformatf("visit #%0d row %0d, want %0d", want.order, got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("visit #%0d col %0d, want %0d", want.order, got.col, want.col));
      if (got.order !== want.order)
        report($sformatf("visit order %0d, want %0d", got.order, want.order));
      if (got.last !== want.last)
        report($sformatf("visit #%0d last %b, want %b", want.order, got.last, want.last));
      if (got.why !== want.why)
        report($sformatf("visit #%0d end reason %b, want %b", want.order, got.why, want.why));
    endtask
  endclass

  logic clk;
  logic rst;

  gscw_cell_if  cell_in ();
  gscw_visit_if visit_out ();
  gscw_cfg_if   cfg ();

  grid_spiral_coverage_walker_core #(
    .MAX_DIM(GRID_DIM)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cell_in(cell_in),
    .visit_out(visit_out),
    .cfg(cfg)
  );

  walk_checker board = new();
  visit_t      got_visit;
  bit          feed_steady = 1'b0;
  int          filled = 0;
  int          cells_sent = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) board.set_reg(cfg.index, cfg.data);
      if (cell_in.valid && cell_in.ready)
        board.store_cell(cell_in.cell_blocked, cell_in.last_cell);
      if (visit_out.valid && visit_out.ready) begin
        got_visit.row = visit_out.visit_row;
        got_visit.col = visit_out.visit_col;
        got_visit.order = visit_out.visit_order;
        got_visit.last = visit_out.last_visit;
        got_visit.why = end_reason_t'(visit_out.end_reason);
        board.check_visit(got_visit);
      end
    end
  end

  task automatic send_cell(bit blk, bit lst);
    int gap;
    if ($urandom_range(0, 19) == 0) feed_steady = !feed_steady;
    gap = feed_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      cell_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_in.valid <= 1'b1;
    cell_in.cell_blocked <= blk;
    cell_in.last_cell <= lst;
    @(posedge clk);
    while (!cell_in.ready) @(posedge clk);
  endtask

  task automatic load_grid(logic [GRID_CELLS-1:0] pattern, int count);
    for (int i = 0; i < count; i++) begin
      send_cell(i < GRID_CELLS ? pattern[i] : 1'($urandom_range(0, 1)), i == count - 1);
    end
    if (count >= GRID_CELLS) filled = GRID_CELLS;
    else if (count > filled) filled = count;
  endtask

  task automatic wait_idle();
    cell_in.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DIM_CFG_W-1:0] pick_dim();
    if ($urandom_range(0, 5) == 0) return DIM_CFG_W'($urandom_range(0, 15));
    return DIM_CFG_W'($urandom_range(1, GRID_DIM));
  endfunction

  task automatic shuffle_config();
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    word = CFG_DATA_W'($urandom);
    word[DIM_CFG_W-1:0] = pick_dim();
    write_reg(REG_GRID_ROWS, word);
    word = CFG_DATA_W'($urandom);
    word[DIM_CFG_W-1:0] = pick_dim();
    write_reg(REG_GRID_COLS, word);
    case ($urandom_range(0, 5))
      0: word = '0;
      1: word = '1;
      2, 3: word = CFG_DATA_W'($urandom_range(1, 20));
      default: word = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_STEP_LIMIT, word);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  initial begin
    int free_stall;
    bit out_steady;
    out_steady = 1'b0;
    visit_out.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) out_steady = !out_steady;
      free_stall = out_steady ? 0 : $urandom_range(0, 14);
      if (free_stall > 0) begin
        visit_out.ready <= 1'b0;
        repeat (free_stall) @(posedge clk);
      end
      visit_out.ready <= 1'b1;
      @(posedge clk);
      while (!visit_out.valid) @(posedge clk);
    end
  end

  initial begin
    logic [GRID_CELLS-1:0] pattern;
    int cells;
    int count;
    int density;
    int shape;
    rst <= 1'b1;
    cell_in.valid <= 1'b0;
    cell_in.cell_blocked <= 1'b0;
    cell_in.last_cell <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_GRID_ROWS;
    cfg.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single blocked start cell
    write_reg(REG_GRID_ROWS, 10'd1);
    write_reg(REG_GRID_COLS, 10'd1);
    load_grid(64'h1, 1);

    // zero dimensions act as one
    wait_idle();
    write_reg(REG_GRID_ROWS, 10'h3F0);
    write_reg(REG_GRID_COLS, 10'h000);
    load_grid(64'h0, 1);

    // zero step limit
    wait_idle();
    write_reg(REG_GRID_ROWS, 10'd2);
    write_reg(REG_GRID_COLS, 10'd2);
    write_reg(REG_STEP_LIMIT, 10'd0);
    load_grid(64'h8, 4);

    wait_idle();
    write_reg(REG_STEP_LIMIT, 10'h3FF);
    write_reg(REG_UNUSED, 10'h2AA);
    write_reg(REG_GRID_ROWS, 10'd2);
    write_reg(REG_GRID_COLS, 10'd3);
    load_grid(64'h4, 6);

    // oversized rows clamp to the maximum
    wait_idle();
    write_reg(REG_GRID_ROWS, 10'd15);
    write_reg(REG_GRID_COLS, 10'd1);
    load_grid(64'h0, 8);

    // step limit hit mid walk
    wait_idle();
    write_reg(REG_GRID_ROWS, 10'd2);
    write_reg(REG_GRID_COLS, 10'd2);
    write_reg(REG_STEP_LIMIT, 10'd3);
    load_grid(64'h0, 4);

    wait_idle();
    write_reg(REG_GRID_ROWS, 10'd8);
    write_reg(REG_GRID_COLS, 10'd8);
    write_reg(REG_STEP_LIMIT, 10'h3FF);

    while (cells_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) shuffle_config();
      cells = board.grid_cells();
      density = $urandom_range(0, 45);
      for (int i = 0; i < GRID_CELLS; i++) pattern[i] = $urandom_range(0, 99) < density;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        count = cells + $urandom_range(1, 70);
      end else if (shape == 1 && cells > 1 && filled >= cells) begin
        count = $urandom_range(1, cells - 1);
      end else begin
        count = cells;
      end
      load_grid(pattern, count);
      cells_sent += count;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
